>>> rtl/assert_macros.svh
// Assertion helpers; clk and rst_n must be visible where these are used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expression holds on every clock out of reset
`define ASSERT_ALWAYS(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// same-cycle implication
`define ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/mccwc_pkg.sv
package mccwc_pkg;

    localparam int DEF_MAX_AMOUNT = 1023;
    localparam int TARGET_W       = 10;
    localparam int COIN_W         = 10;
    localparam int WAYS_W         = 32;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SWEEP,
        ST_DRAIN,
        ST_ANS_RD,
        ST_ANS_WAIT
    } state_t;

    typedef struct packed {
        logic rd_en;     // read both ports this cycle
        logic sweep;     // read belongs to a sweep, update follows next cycle
        logic clr;       // clearing write this cycle
        logic ans_load;  // answer data is taken into the result register
    } ctl_t;

endpackage

>>> rtl/mccwc_ram.sv
module mccwc_ram #(
    parameter int DEPTH = mccwc_pkg::DEF_MAX_AMOUNT + 1,
    parameter int AW    = $clog2(mccwc_pkg::DEF_MAX_AMOUNT + 1),
    parameter int DW    = 32
) (
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [DW-1:0] wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr_a,
    input  logic [AW-1:0] rd_addr_b,
    output logic [DW-1:0] rd_data_a,
    output logic [DW-1:0] rd_data_b
);

    logic [DW-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read data holds while rd_en is low
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_a <= mem[rd_addr_a];
            rd_data_b <= mem[rd_addr_b];
        end
    end

endmodule

>>> rtl/mccwc_seq.sv
module mccwc_seq #(
    parameter int MAX_AMOUNT = mccwc_pkg::DEF_MAX_AMOUNT,
    parameter int AW         = $clog2(mccwc_pkg::DEF_MAX_AMOUNT + 1)
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            coin_valid,
    output logic                            coin_stall,
    input  logic [mccwc_pkg::COIN_W-1:0]    coin_value,
    input  logic                            last_coin,
    input  logic [mccwc_pkg::TARGET_W-1:0]  target_amount,
    input  logic                            result_free,
    output logic [AW-1:0]                   addr_a,
    output logic [AW-1:0]                   addr_b,
    output logic [AW-1:0]                   clr_addr,
    output mccwc_pkg::ctl_t                 ctl
);

    `include "assert_macros.svh"

    localparam int TW = (AW > mccwc_pkg::TARGET_W) ? AW : mccwc_pkg::TARGET_W;
    localparam logic [TW-1:0] MAX_EXT = TW'(MAX_AMOUNT);
    localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_AMOUNT);

    mccwc_pkg::state_t state_reg, state_next;
    logic [AW-1:0] amt_reg, amt_next;
    logic [AW-1:0] src_reg, src_next;
    logic [AW-1:0] tgt_reg, tgt_next;
    logic [AW-1:0] clr_reg, clr_next;
    logic          last_reg, last_next;

    logic [TW-1:0] target_ext;
    logic [TW-1:0] coin_ext;
    logic [AW-1:0] tgt_clamped;
    logic          accept;
    logic          skip;

    always_comb
    begin
        target_ext  = TW'(target_amount);
        coin_ext    = TW'(coin_value);
        tgt_clamped = (target_ext > MAX_EXT) ? MAX_EXT[AW-1:0] : target_ext[AW-1:0];
        // zero coin or coin above target leaves the rows alone
        skip        = (coin_value == '0) || (coin_ext > TW'(tgt_clamped));
        accept      = coin_valid && (state_reg == mccwc_pkg::ST_IDLE);
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            mccwc_pkg::ST_CLEAR:
            begin
                if (clr_reg == LAST_ADDR)
                    state_next = mccwc_pkg::ST_IDLE;
            end
            mccwc_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    if (!skip)
                        state_next = mccwc_pkg::ST_SWEEP;
                    else if (last_coin)
                        state_next = mccwc_pkg::ST_ANS_RD;
                end
            end
            mccwc_pkg::ST_SWEEP:
            begin
                if (amt_reg == tgt_reg)
                    state_next = mccwc_pkg::ST_DRAIN;
            end
            mccwc_pkg::ST_DRAIN:
            begin
                state_next = last_reg ? mccwc_pkg::ST_ANS_RD : mccwc_pkg::ST_IDLE;
            end
            mccwc_pkg::ST_ANS_RD:
            begin
                state_next = mccwc_pkg::ST_ANS_WAIT;
            end
            mccwc_pkg::ST_ANS_WAIT:
            begin
                if (result_free)
                    state_next = mccwc_pkg::ST_CLEAR;
            end
            default:
            begin
                state_next = mccwc_pkg::ST_CLEAR;
            end
        endcase
    end

    // counters and latched request
    always_comb
    begin
        amt_next  = amt_reg;
        src_next  = src_reg;
        tgt_next  = tgt_reg;
        last_next = last_reg;
        clr_next  = clr_reg;
        if (accept)
        begin
            tgt_next  = tgt_clamped;
            last_next = last_coin;
            amt_next  = coin_ext[AW-1:0];
            src_next  = '0;
        end
        else if (state_reg == mccwc_pkg::ST_SWEEP && amt_reg != tgt_reg)
        begin
            amt_next = AW'(amt_reg + 1'b1);
            src_next = AW'(src_reg + 1'b1);
        end
        if (state_reg == mccwc_pkg::ST_ANS_WAIT)
            clr_next = '0;
        else if (state_reg == mccwc_pkg::ST_CLEAR && clr_reg != LAST_ADDR)
            clr_next = AW'(clr_reg + 1'b1);
    end

    // outputs
    always_comb
    begin
        coin_stall   = (state_reg != mccwc_pkg::ST_IDLE);
        addr_a       = src_reg;
        addr_b       = (state_reg == mccwc_pkg::ST_ANS_RD) ? tgt_reg : amt_reg;
        clr_addr     = clr_reg;
        ctl.rd_en    = (state_reg == mccwc_pkg::ST_SWEEP) ||
                       (state_reg == mccwc_pkg::ST_ANS_RD);
        ctl.sweep    = (state_reg == mccwc_pkg::ST_SWEEP);
        ctl.clr      = (state_reg == mccwc_pkg::ST_CLEAR);
        ctl.ans_load = (state_reg == mccwc_pkg::ST_ANS_WAIT) && result_free;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mccwc_pkg::ST_CLEAR;
            clr_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        amt_reg  <= amt_next;
        src_reg  <= src_next;
        tgt_reg  <= tgt_next;
        last_reg <= last_next;
    end

    `ASSERT_IMPL(a_sweep_in_range, state_reg == mccwc_pkg::ST_SWEEP, amt_reg <= tgt_reg,
        "sweep amount beyond target")
    `ASSERT_NEXT(a_sweep_steps, state_reg == mccwc_pkg::ST_SWEEP && amt_reg != tgt_reg,
        state_reg == mccwc_pkg::ST_SWEEP && amt_reg == AW'($past(amt_reg) + 1'b1),
        "sweep did not advance by one amount")

endmodule

>>> rtl/min_coin_change_way_counter.sv
// Channel   Direction  Handshake                Payload
// coin      in         coin_valid / coin_stall  coin_value[9:0], last_coin
// result    out        result_valid / result_stall  way_count[31:0]
// cfg       in         cfg_write                cfg_data[9:0] (target amount)
//
// A coin that changes nothing leaves the rows alone and needs no sweep;
// otherwise one amount per cycle through the single write port of each row.
// A last coin adds the answer read, then a clearing pass over all
// MAX_AMOUNT+1 amounts; the same pass runs after reset. coin_stall is high
// throughout. A stalled result holds; the next answer waits for it.
module min_coin_change_way_counter #(
    parameter int MAX_AMOUNT = mccwc_pkg::DEF_MAX_AMOUNT
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               coin_valid,
    output logic                               coin_stall,
    input  logic [mccwc_pkg::COIN_W-1:0]       coin_value,
    input  logic                               last_coin,
    output logic                               result_valid,
    input  logic                               result_stall,
    output logic [mccwc_pkg::WAYS_W-1:0]       way_count,
    input  logic                               cfg_write,
    input  logic [mccwc_pkg::TARGET_W-1:0]     cfg_data
);

    `include "assert_macros.svh"

    localparam int AW    = $clog2(MAX_AMOUNT + 1);
    localparam int CW    = $clog2(MAX_AMOUNT + 2);
    localparam int WW    = mccwc_pkg::WAYS_W;
    localparam int DEPTH = MAX_AMOUNT + 1;
    localparam logic [CW-1:0] UNREACH = {CW{1'b1}};

    logic [mccwc_pkg::TARGET_W-1:0] target_reg;
    logic                           result_valid_reg;
    logic [WW-1:0]                  way_count_reg;

    logic [AW-1:0]   addr_a, addr_b, clr_addr;
    mccwc_pkg::ctl_t ctl;
    logic            result_free;

    logic            s1_valid_reg;
    logic [AW-1:0]   s1_amt_reg, s1_src_reg;
    logic            fwd_valid_reg;
    logic [AW-1:0]   fwd_addr_reg;
    logic [CW-1:0]   fwd_min_reg;
    logic [WW-1:0]   fwd_ways_reg;

    logic [CW-1:0]   min_rd_a, min_rd_b;
    logic [WW-1:0]   ways_rd_a, ways_rd_b;

    logic            fwd_hit;
    logic [CW-1:0]   from_min, cand, upd_min;
    logic [WW-1:0]   from_ways, upd_ways;
    logic [WW:0]     ways_sum;

    logic            wr_en;
    logic [AW-1:0]   wr_addr;
    logic [CW-1:0]   wr_min;
    logic [WW-1:0]   wr_ways;

    assign result_free = !result_valid_reg || !result_stall;

    mccwc_seq #(
        .MAX_AMOUNT (MAX_AMOUNT),
        .AW         (AW)
    ) u_seq (
        .clk           (clk),
        .rst_n         (rst_n),
        .coin_valid    (coin_valid),
        .coin_stall    (coin_stall),
        .coin_value    (coin_value),
        .last_coin     (last_coin),
        .target_amount (target_reg),
        .result_free   (result_free),
        .addr_a        (addr_a),
        .addr_b        (addr_b),
        .clr_addr      (clr_addr),
        .ctl           (ctl)
    );

    mccwc_ram #(
        .DEPTH (DEPTH),
        .AW    (AW),
        .DW    (CW)
    ) u_min_ram (
        .clk       (clk),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_min),
        .rd_en     (ctl.rd_en),
        .rd_addr_a (addr_a),
        .rd_addr_b (addr_b),
        .rd_data_a (min_rd_a),
        .rd_data_b (min_rd_b)
    );

    mccwc_ram #(
        .DEPTH (DEPTH),
        .AW    (AW),
        .DW    (WW)
    ) u_ways_ram (
        .clk       (clk),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_ways),
        .rd_en     (ctl.rd_en),
        .rd_addr_a (addr_a),
        .rd_addr_b (addr_b),
        .rd_data_a (ways_rd_a),
        .rd_data_b (ways_rd_b)
    );

    // update stage: source entry may be the one written last cycle (unit coin)
    always_comb
    begin
        fwd_hit   = fwd_valid_reg && (fwd_addr_reg == s1_src_reg);
        from_min  = fwd_hit ? fwd_min_reg  : min_rd_a;
        from_ways = fwd_hit ? fwd_ways_reg : ways_rd_a;
        cand      = CW'(from_min + 1'b1);
        ways_sum  = {1'b0, ways_rd_b} + {1'b0, from_ways};
        upd_min   = min_rd_b;
        upd_ways  = ways_rd_b;
        if (from_min != UNREACH)
        begin
            if (min_rd_b == UNREACH || min_rd_b > cand)
            begin
                upd_min  = cand;
                upd_ways = from_ways;
            end
            else if (min_rd_b == cand)
            begin
                upd_ways = ways_sum[WW] ? {WW{1'b1}} : ways_sum[WW-1:0];
            end
        end
    end

    always_comb
    begin
        wr_en = s1_valid_reg || ctl.clr;
        if (ctl.clr)
        begin
            wr_addr = clr_addr;
            wr_min  = (clr_addr == '0) ? '0 : UNREACH;
            wr_ways = (clr_addr == '0) ? WW'(1) : '0;
        end
        else
        begin
            wr_addr = s1_amt_reg;
            wr_min  = upd_min;
            wr_ways = upd_ways;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg       <= '0;
            result_valid_reg <= 1'b0;
            s1_valid_reg     <= 1'b0;
            fwd_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_write)
                target_reg <= cfg_data;
            if (ctl.ans_load)
                result_valid_reg <= 1'b1;
            else if (!result_stall)
                result_valid_reg <= 1'b0;
            s1_valid_reg  <= ctl.sweep;
            fwd_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_amt_reg   <= addr_b;
        s1_src_reg   <= addr_a;
        fwd_addr_reg <= s1_amt_reg;
        fwd_min_reg  <= upd_min;
        fwd_ways_reg <= upd_ways;
        if (ctl.ans_load)
            way_count_reg <= ways_rd_b;
    end

    assign result_valid = result_valid_reg;
    assign way_count    = way_count_reg;

    `ASSERT_IMPL(a_src_below_amt, s1_valid_reg, s1_amt_reg > s1_src_reg,
        "update source not below destination")
    `ASSERT_ALWAYS(a_no_clear_in_sweep, !(s1_valid_reg && ctl.clr),
        "clear write collides with sweep write")
    `ASSERT_NEXT(a_answer_shown, ctl.ans_load, result_valid_reg,
        "answer load did not raise result_valid")

endmodule
